>>> hdl/smsa_pkg.sv
`timescale 1ns / 1ps

package smsa_pkg;

    localparam int MAX_EQUATIONS = 4096;
    localparam int PROFILE_DEPTH = 65536;
    localparam int SUM_WIDTH     = 48;

    localparam int CS_DEPTH  = MAX_EQUATIONS + 1;
    localparam int CS_AW     = $clog2(CS_DEPTH);
    localparam int ST_AW     = $clog2(PROFILE_DEPTH);
    localparam int SUM_EXT_W = SUM_WIDTH + 1;

    localparam int CS_W    = 17;
    localparam int DOF_W   = 16;
    localparam int DOFX_W  = 17;
    localparam int POS_W   = 18;
    localparam int OUT_SUM_W = 48;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 13;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_ADD  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [2:0] ST_DONE        = 3'd0;
    localparam logic [2:0] ST_CONSTRAINED = 3'd1;
    localparam logic [2:0] ST_UPPER       = 3'd2;
    localparam logic [2:0] ST_NOT_OWNER   = 3'd3;
    localparam logic [2:0] ST_OUTSIDE     = 3'd4;
    localparam logic [2:0] ST_SATURATED   = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_EQUATION_COUNT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_RANK       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWNER_CHECK_ON = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASS_ENABLE    = 8'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [DOF_W-1:0]   row_dof;
        logic [DOF_W-1:0]   col_dof;
        logic [7:0]         row_owner;
        logic signed [31:0] stiff_value;
        logic signed [31:0] mass_value;
        logic [CS_W-1:0]    column_start;
    } in_item_t;

    typedef struct packed {
        logic [2:0]                  status;
        logic [DOF_W-1:0]            profile_index;
        logic signed [OUT_SUM_W-1:0] stiff_sum;
        logic signed [OUT_SUM_W-1:0] mass_sum;
    } out_item_t;

endpackage

>>> hdl/skyline_matrix_scatter_add.sv
`timescale 1ns / 1ps

// Scatter-add engine for a skyline stiffness/mass matrix pair.
// Channels: in (in_valid/in_ready, in_item) takes load, add and read
// requests; out (out_valid/out_ready, out_item) returns one item per
// request; cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// registers equation_count, own_rank, owner_check_on, mass_enable and is
// always ready. Write cfg only while the engine is idle.
// Flow: a load or an unused request code goes from accept straight to
// S_OUT; an add/read skipped by a check passes S_LOOK first; one that
// reaches the store passes S_LOOK and S_ACC. One item is in flight at a
// time; the steps are the column start lookup and then the store
// read-modify-write, each one synchronous memory read.
// Reset: registers clear, then a clearing pass over all PROFILE_DEPTH
// entries (65536) zeroes both value stores with in_ready low; cfg writes are taken.
// Column starts are not cleared and must be loaded before use.
// Stall: the result sits in an output register; the engine accepts the next
// item meanwhile and holds its own result until the register frees up.
module skyline_matrix_scatter_add
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  smsa_pkg::in_item_t                 in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output smsa_pkg::out_item_t                out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [smsa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [smsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_ACC,
        S_OUT
    } state_t;

    typedef logic [smsa_pkg::CS_AW-1:0]         cs_addr_t;
    typedef logic [smsa_pkg::ST_AW-1:0]         st_addr_t;
    typedef logic signed [smsa_pkg::SUM_WIDTH-1:0]  sum_t;
    typedef logic signed [smsa_pkg::SUM_EXT_W-1:0]  sum_ext_t;

    typedef struct packed {
        logic sat;
        sum_t value;
    } sat_res_t;

    function automatic sat_res_t sat_add(sum_t a, logic signed [31:0] b);
        sum_ext_t s;
        sat_res_t r;
        s = sum_ext_t'(a) + sum_ext_t'(b);
        r.sat = s[smsa_pkg::SUM_EXT_W-1] != s[smsa_pkg::SUM_WIDTH-1];
        if (!r.sat)
        begin
            r.value = s[smsa_pkg::SUM_WIDTH-1:0];
        end
        else if (s[smsa_pkg::SUM_EXT_W-1])
        begin
            r.value = {1'b1, {(smsa_pkg::SUM_WIDTH-1){1'b0}}};
        end
        else
        begin
            r.value = {1'b0, {(smsa_pkg::SUM_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration
    logic [smsa_pkg::CFG_DATA_W-1:0] eq_count_reg;
    logic [7:0]                      own_rank_reg;
    logic                            owner_check_reg;
    logic                            mass_en_reg;

    state_t                  state_reg;
    st_addr_t                clr_cnt_reg;
    smsa_pkg::in_item_t      req_reg;
    st_addr_t                pos_reg;
    smsa_pkg::out_item_t     res_reg;
    logic                    out_valid_reg;
    smsa_pkg::out_item_t     out_item_reg;

    // memories
    logic [smsa_pkg::CS_W-1:0]  cs_mem [smsa_pkg::CS_DEPTH];
    logic [smsa_pkg::CS_W-1:0]  cs_lo_reg;
    logic [smsa_pkg::CS_W-1:0]  cs_hi_reg;
    sum_t                       stiff_mem [smsa_pkg::PROFILE_DEPTH];
    sum_t                       mass_mem  [smsa_pkg::PROFILE_DEPTH];
    sum_t                       stiff_q_reg;
    sum_t                       mass_q_reg;

    logic                       in_acc;
    logic                       load_ok;
    logic [smsa_pkg::DOFX_W-1:0] row_p1;
    logic                       cs_we;
    logic                       cs_re;
    smsa_pkg::out_item_t        load_res;

    logic [smsa_pkg::DOFX_W-1:0] neq;
    logic [smsa_pkg::DOFX_W-1:0] eq_ext;
    logic                        row_con;
    logic                        col_con;
    logic                        not_owner;
    logic                        upper;
    logic signed [smsa_pkg::POS_W-1:0] height;
    logic [smsa_pkg::DOF_W-1:0]  span;
    logic [smsa_pkg::POS_W-1:0]  pos;
    logic                        outside;
    logic [2:0]                  look_status;
    logic                        look_skip;
    smsa_pkg::out_item_t         look_res;

    logic                        is_add;
    sat_res_t                    stiff_upd;
    sat_res_t                    mass_upd;
    logic                        st_re;
    logic                        stiff_we;
    logic                        mass_we;
    st_addr_t                    st_waddr;
    sum_t                        stiff_wdata;
    sum_t                        mass_wdata;
    smsa_pkg::out_item_t         acc_res;
    logic                        out_free;

    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_count_reg    <= '0;
            own_rank_reg    <= '0;
            owner_check_reg <= 1'b0;
            mass_en_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                smsa_pkg::CFG_EQUATION_COUNT: eq_count_reg    <= cfg_data;
                smsa_pkg::CFG_OWN_RANK:       own_rank_reg    <= cfg_data[7:0];
                smsa_pkg::CFG_OWNER_CHECK_ON: owner_check_reg <= cfg_data[0];
                smsa_pkg::CFG_MASS_ENABLE:    mass_en_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // column start table: one write, two reads (row and row + 1)
    always_comb
    begin
        load_ok = 32'(in_item.row_dof) <= 32'(smsa_pkg::MAX_EQUATIONS);
        row_p1  = smsa_pkg::DOFX_W'(in_item.row_dof) + smsa_pkg::DOFX_W'(1);
        cs_we   = in_acc && in_item.req_type == smsa_pkg::REQ_LOAD && load_ok;
        cs_re   = in_acc;
        load_res = '0;
        if (in_item.req_type == smsa_pkg::REQ_LOAD)
        begin
            if (load_ok)
            begin
                load_res.profile_index = in_item.row_dof;
            end
            else
            begin
                load_res.status = smsa_pkg::ST_OUTSIDE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cs_we)
        begin
            cs_mem[cs_addr_t'(in_item.row_dof)] <= in_item.column_start;
        end
        if (cs_re)
        begin
            cs_lo_reg <= cs_mem[cs_addr_t'(in_item.row_dof)];
            cs_hi_reg <= cs_mem[cs_addr_t'(row_p1)];
        end
    end

    // checks and profile position
    always_comb
    begin
        eq_ext    = smsa_pkg::DOFX_W'(eq_count_reg);
        neq       = (32'(eq_ext) > 32'(smsa_pkg::MAX_EQUATIONS))
                    ? smsa_pkg::DOFX_W'(smsa_pkg::MAX_EQUATIONS) : eq_ext;
        is_add    = req_reg.req_type == smsa_pkg::REQ_ADD;
        row_con   = smsa_pkg::DOFX_W'(req_reg.row_dof) >= neq;
        col_con   = smsa_pkg::DOFX_W'(req_reg.col_dof) >= neq;
        not_owner = is_add && owner_check_reg && req_reg.row_owner != own_rank_reg;
        upper     = req_reg.col_dof > req_reg.row_dof;
        height    = $signed(smsa_pkg::POS_W'(cs_hi_reg)) - $signed(smsa_pkg::POS_W'(cs_lo_reg));
        span      = req_reg.row_dof - req_reg.col_dof;
        pos       = smsa_pkg::POS_W'(cs_lo_reg) + smsa_pkg::POS_W'(span);
        outside   = $signed(smsa_pkg::POS_W'(span)) >= height
                    || 32'(pos) >= 32'(smsa_pkg::PROFILE_DEPTH);
        look_skip = 1'b1;
        priority if (row_con)
        begin
            look_status = smsa_pkg::ST_CONSTRAINED;
        end
        else if (not_owner)
        begin
            look_status = smsa_pkg::ST_NOT_OWNER;
        end
        else if (col_con)
        begin
            look_status = smsa_pkg::ST_CONSTRAINED;
        end
        else if (upper)
        begin
            look_status = smsa_pkg::ST_UPPER;
        end
        else if (outside)
        begin
            look_status = smsa_pkg::ST_OUTSIDE;
        end
        else
        begin
            look_status = smsa_pkg::ST_DONE;
            look_skip   = 1'b0;
        end
        look_res        = '0;
        look_res.status = look_status;
        if (look_status == smsa_pkg::ST_OUTSIDE || !look_skip)
        begin
            look_res.profile_index = pos[smsa_pkg::DOF_W-1:0];
        end
    end

    // value stores: read in S_LOOK, write back in S_ACC on an add, zeroed by the clear pass
    always_comb
    begin
        stiff_upd   = sat_add(stiff_q_reg, req_reg.stiff_value);
        mass_upd    = sat_add(mass_q_reg, req_reg.mass_value);
        st_re       = state_reg == S_LOOK && !look_skip;
        stiff_we    = state_reg == S_CLEAR || (state_reg == S_ACC && is_add);
        mass_we     = state_reg == S_CLEAR || (state_reg == S_ACC && is_add && mass_en_reg);
        st_waddr    = (state_reg == S_CLEAR) ? clr_cnt_reg : pos_reg;
        stiff_wdata = (state_reg == S_CLEAR) ? '0 : stiff_upd.value;
        mass_wdata  = (state_reg == S_CLEAR) ? '0 : mass_upd.value;
        acc_res     = res_reg;
        if (is_add)
        begin
            acc_res.stiff_sum = smsa_pkg::OUT_SUM_W'(stiff_upd.value);
            acc_res.mass_sum  = smsa_pkg::OUT_SUM_W'(mass_en_reg
                                ? mass_upd.value : mass_q_reg);
            if (stiff_upd.sat || (mass_en_reg && mass_upd.sat))
            begin
                acc_res.status = smsa_pkg::ST_SATURATED;
            end
        end
        else
        begin
            acc_res.stiff_sum = smsa_pkg::OUT_SUM_W'(stiff_q_reg);
            acc_res.mass_sum  = smsa_pkg::OUT_SUM_W'(mass_q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stiff_we)
        begin
            stiff_mem[st_waddr] <= stiff_wdata;
        end
        if (st_re)
        begin
            stiff_q_reg <= stiff_mem[st_addr_t'(pos)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mass_we)
        begin
            mass_mem[st_waddr] <= mass_wdata;
        end
        if (st_re)
        begin
            mass_q_reg <= mass_mem[st_addr_t'(pos)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            req_reg       <= '0;
            pos_reg       <= '0;
            res_reg       <= '0;
            out_item_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_cnt_reg == st_addr_t'(smsa_pkg::PROFILE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + st_addr_t'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        req_reg <= in_item;
                        res_reg <= load_res;
                        if (in_item.req_type == smsa_pkg::REQ_LOAD)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (in_item.req_type == smsa_pkg::REQ_ADD
                                 || in_item.req_type == smsa_pkg::REQ_READ)
                        begin
                            state_reg <= S_LOOK;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_LOOK:
                begin
                    res_reg   <= look_res;
                    pos_reg   <= st_addr_t'(pos);
                    state_reg <= look_skip ? S_OUT : S_ACC;
                end
                S_ACC:
                begin
                    res_reg   <= acc_res;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_item_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("accepted item did not start work");

    a_acc_in_profile: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> 32'(pos_reg) < 32'(smsa_pkg::PROFILE_DEPTH))
        else $error("store access outside profile depth");

    a_mass_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        mass_we && state_reg != S_CLEAR |-> mass_en_reg && is_add)
        else $error("mass store written while disabled");

    a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) && $past(state_reg == S_CLEAR)
        |-> $past(clr_cnt_reg) == st_addr_t'(smsa_pkg::PROFILE_DEPTH - 1))
        else $error("clear pass ended early");

endmodule
